[src/isqm_pkg.sv]
`timescale 1ns / 1ps
package isqm_pkg;

  localparam int unsigned MAX_INTERVALS_DEF = 256;
  localparam int unsigned ID_W    = 64;
  localparam int unsigned SUM_W   = ID_W + 1;
  localparam int unsigned HIT_W   = 32;
  localparam int unsigned ICNT_W  = 9;
  localparam int unsigned STAT_W  = 2;

  typedef logic [ID_W-1:0]  id_t;
  typedef logic [SUM_W-1:0] sum_t;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD  = 2'd2;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_CMP,
    CMD_INS,
    CMD_MERGE,
    CMD_SHIFT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    id_t     s;
    id_t     e;
    id_t     q;
  } cmd_t;

  // what a cell shows to its neighbors and to the top level
  typedef struct packed {
    id_t  start;
    id_t  stop;
    logic ov;
    logic gt;
    logic mark;
    logic shift;
    logic keep;
    logic hitq;
  } cell_t;

  // inclusive length, exact in 65 bits
  function automatic sum_t span_len(id_t s, id_t e);
    return {1'b0, e} - {1'b0, s} + sum_t'(1);
  endfunction

endpackage

[src/isqm_if.sv]
`timescale 1ns / 1ps
interface isqm_in_if;
  import isqm_pkg::*;
  logic valid;
  logic ready;
  logic func;
  id_t  range_start;
  id_t  range_end;
  id_t  query_id;
  modport source (output valid, func, range_start, range_end, query_id, input ready);
  modport sink   (input valid, func, range_start, range_end, query_id, output ready);
endinterface

interface isqm_out_if;
  import isqm_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic              hit;
  logic [HIT_W-1:0]  hit_count;
  id_t               covered_total;
  logic [ICNT_W-1:0] interval_count;
  modport source (output valid, status, hit, hit_count, covered_total, interval_count,
                  input ready);
  modport sink   (input valid, status, hit, hit_count, covered_total, interval_count,
                  output ready);
endinterface

[src/isqm_cell.sv]
`timescale 1ns / 1ps
module isqm_cell
  import isqm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cmd_t  cmd,
  input  logic  valid_i,
  input  cell_t left,
  input  cell_t right,
  output cell_t slot
);

  id_t  start_r, stop_r;
  logic ov_r, gt_r, hitq_r;
  logic mark_r, shift_r, keep_r;
  logic first_ov;

  assign first_ov = ov_r && !left.ov;

  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_CMP: begin
        ov_r   <= valid_i && (start_r <= cmd.e) && (cmd.s <= stop_r);
        gt_r   <= !valid_i || (start_r > cmd.e);
        hitq_r <= valid_i && (cmd.q >= start_r) && (cmd.q <= stop_r);
      end
      CMD_INS: begin
        if (gt_r) begin
          if (left.gt) begin
            start_r <= left.start;
            stop_r  <= left.stop;
          end else begin
            start_r <= cmd.s;
            stop_r  <= cmd.e;
          end
        end
      end
      CMD_MERGE: begin
        if (first_ov) begin
          start_r <= (cmd.s < start_r) ? cmd.s : start_r;
          stop_r  <= (cmd.e > stop_r) ? cmd.e : stop_r;
        end
      end
      CMD_SHIFT: begin
        if (shift_r) begin
          start_r <= right.start;
          stop_r  <= right.stop;
        end else if (keep_r && right.mark && right.stop > stop_r) begin
          stop_r <= right.stop;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r  <= 1'b0;
      keep_r  <= 1'b0;
      shift_r <= 1'b0;
    end else begin
      case (cmd.op)
        CMD_CMP: begin
          mark_r  <= 1'b0;
          keep_r  <= 1'b0;
          shift_r <= 1'b0;
        end
        CMD_MERGE: begin
          keep_r  <= first_ov;
          mark_r  <= ov_r && !first_ov;
          shift_r <= (ov_r && !first_ov) || gt_r;
        end
        CMD_SHIFT: begin
          if (shift_r) begin
            mark_r  <= right.mark;
            shift_r <= right.shift;
          end
        end
        default: ;
      endcase
    end
  end

  assign slot = '{start: start_r, stop: stop_r, ov: ov_r, gt: gt_r, mark: mark_r,
                  shift: shift_r, keep: keep_r, hitq: hitq_r};

endmodule

[src/interval_set_merge_and_query_top.sv]
`timescale 1ns / 1ps
// Interval set merge and query.
// in_ch carries one transaction per item: func 0 inserts [range_start, range_end],
// func 1 tests query_id. out_ch returns exactly one transaction per item with
// status, hit, the running hit count, the covered ID total and the interval count.
// Intervals sit in a row of MAX_INTERVALS cells kept sorted by start. Each cell
// compares the latched item against its own interval in parallel; merged cells
// are squeezed out by shifting the row left one place per cycle.
// Path from input transaction to result register: a query, a non-merging insert
// or a rejected insert passes S_CMP, S_EVAL and S_DONE; an insert that merges k
// stored intervals also passes S_SHIFT (one shift per absorbed interval beyond
// the first) and S_FIN before S_DONE.
// One item is in flight at a time; in_ch.ready is high while the block is idle,
// also while a finished result still waits on out_ch.
// If out_ch stalls, the result holds and a following item finishes its work
// and waits until the result register frees up.
// Reset (synchronous, rst_n low) empties the table and clears the hit count and
// covered total; no clearing pass is needed.
module interval_set_merge_and_query_top
  import isqm_pkg::*;
#(
  parameter int unsigned MAX_INTERVALS = MAX_INTERVALS_DEF
) (
  input logic clk,
  input logic rst_n,
  isqm_in_if.sink    in_ch,
  isqm_out_if.source out_ch
);

  localparam int unsigned CNT_W = $clog2(MAX_INTERVALS + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CMP   = 6'b000010,
    S_EVAL  = 6'b000100,
    S_SHIFT = 6'b001000,
    S_FIN   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic               func_r;
  id_t                s_r, e_r, q_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  sum_t               sum_r, sum_nxt;
  logic [HIT_W-1:0]   hits_r, hits_nxt;
  logic [STAT_W-1:0]  status_r, status_nxt;
  logic               hit_r, hit_nxt;
  cmd_t               cmd;

  logic               out_valid_r;
  logic [STAT_W-1:0]  out_status_r;
  logic               out_hit_r;
  logic [HIT_W-1:0]   out_hits_r;
  id_t                out_cov_r;
  logic [ICNT_W-1:0]  out_cnt_r;

  cell_t cells [MAX_INTERVALS];
  cell_t lft   [MAX_INTERVALS];
  cell_t rgt   [MAX_INTERVALS];

  logic in_acc, out_load;
  logic any_ov, any_mark, any_hit, any_keep;
  id_t  fo_s, fo_e, fm_s, fm_e, kp_s, kp_e;

  for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
    logic vld;
    assign vld = (CNT_W'(i) < count_r);
    if (i == 0) begin : g_l0
      assign lft[i] = '0;
    end else begin : g_ln
      assign lft[i] = cells[i-1];
    end
    if (i == MAX_INTERVALS - 1) begin : g_rl
      assign rgt[i] = '{start: '0, stop: '0, ov: 1'b0, gt: 1'b1, mark: 1'b0,
                        shift: 1'b1, keep: 1'b0, hitq: 1'b0};
    end else begin : g_rn
      assign rgt[i] = cells[i+1];
    end
    isqm_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (cmd),
      .valid_i(vld),
      .left   (lft[i]),
      .right  (rgt[i]),
      .slot   (cells[i])
    );
  end

  // one-hot selections out of the row
  always_comb begin
    any_ov = 1'b0; any_mark = 1'b0; any_hit = 1'b0; any_keep = 1'b0;
    fo_s = '0; fo_e = '0; fm_s = '0; fm_e = '0; kp_s = '0; kp_e = '0;
    for (int i = 0; i < MAX_INTERVALS; i++) begin
      any_ov   |= cells[i].ov;
      any_mark |= cells[i].mark;
      any_hit  |= cells[i].hitq;
      any_keep |= cells[i].keep;
      if (cells[i].ov && !lft[i].ov) begin
        fo_s |= cells[i].start;
        fo_e |= cells[i].stop;
      end
      if (cells[i].mark && !lft[i].mark) begin
        fm_s |= cells[i].start;
        fm_e |= cells[i].stop;
      end
      if (cells[i].keep) begin
        kp_s |= cells[i].start;
        kp_e |= cells[i].stop;
      end
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    sum_nxt    = sum_r;
    hits_nxt   = hits_r;
    status_nxt = status_r;
    hit_nxt    = hit_r;
    cmd        = '{op: CMD_NONE, s: s_r, e: e_r, q: q_r};
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_CMP;
      S_CMP: begin
        cmd.op    = CMD_CMP;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        status_nxt = STAT_OK;
        hit_nxt    = 1'b0;
        state_nxt  = S_DONE;
        if (func_r == FUNC_QUERY) begin
          hit_nxt = any_hit;
          if (any_hit && hits_r != '1) hits_nxt = hits_r + HIT_W'(1);
        end else if (s_r > e_r) begin
          status_nxt = STAT_BAD;
        end else if (!any_ov) begin
          if (count_r == CNT_W'(MAX_INTERVALS)) begin
            status_nxt = STAT_FULL;
          end else begin
            cmd.op    = CMD_INS;
            count_nxt = count_r + CNT_W'(1);
            sum_nxt   = sum_r + span_len(s_r, e_r);
          end
        end else begin
          cmd.op    = CMD_MERGE;
          sum_nxt   = sum_r - span_len(fo_s, fo_e);
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (any_mark) begin
          cmd.op    = CMD_SHIFT;
          sum_nxt   = sum_r - span_len(fm_s, fm_e);
          count_nxt = count_r - CNT_W'(1);
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        sum_nxt   = sum_r + span_len(kp_s, kp_e);
        state_nxt = S_DONE;
      end
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      hits_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      hits_r  <= hits_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    hit_r    <= hit_nxt;
    if (in_acc) begin
      func_r <= in_ch.func;
      s_r    <= in_ch.range_start;
      e_r    <= in_ch.range_end;
      q_r    <= in_ch.query_id;
    end
    if (out_load) begin
      out_status_r <= status_r;
      out_hit_r    <= hit_r;
      out_hits_r   <= hits_r;
      out_cov_r    <= sum_r[SUM_W-1] ? '1 : sum_r[ID_W-1:0];
      out_cnt_r    <= ICNT_W'(count_r);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.hit            = out_hit_r;
  assign out_ch.hit_count      = out_hits_r;
  assign out_ch.covered_total  = out_cov_r;
  assign out_ch.interval_count = out_cnt_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_INTERVALS))
    else $error("interval count above table size");

  a_accept_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_CMP)
    else $error("accepted transaction did not start compare");

  a_mark_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && any_mark) |-> any_keep)
    else $error("merged cells pending without a surviving cell");

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!sum_r[SUM_W-1] || sum_r[ID_W-1:0] == '0))
    else $error("covered total above the ID space");

endmodule
